>>> hw/rtl/sskc_pkg.sv
// ----------------------------------------------------------------------------
// sskc_pkg: shared types and constants of the sidechain compressor
// Request payloads, register indexes, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sskc_pkg;

	localparam int unsigned SAMPLE_BITS = 24;
	localparam int unsigned RED_BITS    = 15;
	localparam int unsigned CFG_ADDR_W  = 4;
	localparam int unsigned CFG_DATA_W  = 25;

	localparam int unsigned MUL_W  = 34;
	localparam int unsigned PROD_W = 2 * MUL_W;

	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KNEE      = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SLOPE     = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ATTACK    = 4'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 4'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_WET       = 4'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_BP_B0     = 4'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_BP_A1     = 4'd7;

	localparam logic [21:0] DB_PER_LOG2 = 22'd394566;
	localparam logic [21:0] LOG2_PER_DB = 22'd2786635;
	localparam int          DB_FLOOR    = -25600;
	localparam int          RED_MAX     = 25600;
	localparam int          LEVEL_MAX   = 8388607;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] main_sample;
		logic signed [SAMPLE_BITS-1:0] sidechain_sample;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic [RED_BITS-1:0]           reduction_db;
	} result_t;

	// round half up, then arithmetic shift
	function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
		input int unsigned s);
		logic signed [PROD_W-1:0] half;
		half = $signed(PROD_W'(1) << (s - 1));
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [PROD_W-1:0] sat_s(input logic signed [PROD_W-1:0] v,
		input int unsigned bits);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = $signed((PROD_W'(1) << (bits - 1)) - PROD_W'(1));
		lo = ~hi;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sskc_mul.sv
// ----------------------------------------------------------------------------
// sskc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sskc_mul (
	input  wire logic                                 clk,
	input  wire logic signed [sskc_pkg::MUL_W-1:0]    a,
	input  wire logic signed [sskc_pkg::MUL_W-1:0]    b,
	output logic signed      [sskc_pkg::PROD_W-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

>>> hw/rtl/sidechain_soft_knee_compressor.sv
// ----------------------------------------------------------------------------
// sidechain_soft_knee_compressor: soft-knee compressor keyed by a sidechain
// Bandpass detector, peak envelope, dB knee curve, gain and dry/wet mix.
// ----------------------------------------------------------------------------
// Usage:
//  sample (valid/ready) carries one main and one sidechain sample per request.
//  result (valid/ready) returns the compressed sample and the gain reduction.
//  cfg (valid/ready) writes one register by index; cfg_ready is always high.
//  Write registers only while no request is in flight.
//  The next request is taken once the result is written and the sequencer
//  is back in idle. Most of the time goes to the 16 square roots of the
//  dB-to-gain step on the bit-serial root unit and to the log2 normalize
//  and squaring loop. All products go through one shared 34x34 multiplier.
//  sample_ready is high only between requests. The result sits in an output
//  register: a new request is taken while it waits. If the receiver still
//  stalls when the next result is done, the sequencer holds in its last step
//  until the register frees.
//  Reset clears filter states, envelope and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sidechain_soft_knee_compressor (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    sample_valid,
	output logic                                         sample_ready,
	input  wire sskc_pkg::sample_t                       sample,
	output logic                                         result_valid,
	input  wire logic                                    result_ready,
	output sskc_pkg::result_t                            result,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [sskc_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  wire logic [sskc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	localparam int unsigned SB = sskc_pkg::SAMPLE_BITS;
	localparam int unsigned PW = sskc_pkg::PROD_W;
	localparam int unsigned MW = sskc_pkg::MUL_W;
	localparam int unsigned SC_SHR = (SB > 24) ? SB - 24 : 0;
	localparam int unsigned SC_SHL = (SB < 24) ? 24 - SB : 0;

	typedef enum logic [28:0] {
		ST_IDLE    = 29'd1 << 0,
		ST_F_B0    = 29'd1 << 1,
		ST_F_Y     = 29'd1 << 2,
		ST_F_A1    = 29'd1 << 3,
		ST_F_A2    = 29'd1 << 4,
		ST_F_S2    = 29'd1 << 5,
		ST_E_MUL   = 29'd1 << 6,
		ST_E_UPD   = 29'd1 << 7,
		ST_L_NORM  = 29'd1 << 8,
		ST_L_SQ    = 29'd1 << 9,
		ST_L_FIX   = 29'd1 << 10,
		ST_L_DB    = 29'd1 << 11,
		ST_L_CLAMP = 29'd1 << 12,
		ST_K_DIFF  = 29'd1 << 13,
		ST_K_SEL   = 29'd1 << 14,
		ST_K_HARD  = 29'd1 << 15,
		ST_K_UU    = 29'd1 << 16,
		ST_K_US    = 29'd1 << 17,
		ST_K_NUM   = 29'd1 << 18,
		ST_K_DIV   = 29'd1 << 19,
		ST_G_MUL   = 29'd1 << 20,
		ST_G_L     = 29'd1 << 21,
		ST_R_INIT  = 29'd1 << 22,
		ST_R_STEP  = 29'd1 << 23,
		ST_G_SHIFT = 29'd1 << 24,
		ST_M_GW    = 29'd1 << 25,
		ST_M_G     = 29'd1 << 26,
		ST_M_X     = 29'd1 << 27,
		ST_M_OUT   = 29'd1 << 28
	} state_t;

	state_t state_q;

	// registers
	logic signed [15:0] thr_q;
	logic [12:0]        knee_q;
	logic [16:0]        slope_q;
	logic [24:0]        att_q;
	logic [24:0]        rel_q;
	logic [16:0]        wet_q;
	logic [23:0]        b0_q;
	logic signed [23:0] a1_q;

	// state
	logic signed [31:0] s1_q;
	logic signed [31:0] s2_q;
	logic [22:0]        env_q;

	// working registers
	logic signed [SB-1:0] x_q;
	logic signed [23:0]   sc_q;
	logic signed [23:0]   y_q;
	logic signed [47:0]   acc_q;
	logic signed [23:0]   ed_q;
	logic [24:0]          cf_q;
	logic [24:0]          m_q;
	logic [4:0]           exp_q;
	logic [15:0]          frac_q;
	logic [3:0]           cnt_q;
	logic signed [15:0]   db_q;
	logic signed [16:0]   diff_q;
	logic [13:0]          u_q;
	logic [12:0]          rem_q;
	logic [11:0]          qn_q;
	logic [14:0]          red_q;
	logic [20:0]          l_q;
	logic [24:0]          t_q;
	logic [48:0]          rv_q;
	logic [48:0]          rt_q;
	logic [4:0]           sb_q;
	logic [24:0]          g_q;
	logic signed [25:0]   gm_q;
	logic                 res_valid_q;
	sskc_pkg::result_t    res_q;

	// shared multiplier
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] p_q;

	sskc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p_q)
	);

	// clamped register views
	logic [16:0]        slope_c;
	logic [16:0]        wet_c;
	logic [24:0]        att_c;
	logic [24:0]        rel_c;
	logic signed [25:0] a2;

	assign slope_c = (slope_q > 17'd65536) ? 17'd65536 : slope_q;
	assign wet_c   = (wet_q > 17'd65536) ? 17'd65536 : wet_q;
	assign att_c   = (att_q > 25'd16777216) ? 25'd16777216 : att_q;
	assign rel_c   = (rel_q > 25'd16777216) ? 25'd16777216 : rel_q;
	assign a2      = $signed(26'd16777216) - $signed({1'b0, b0_q, 1'b0});

	// datapath
	logic signed [31:0]   sc_ext;
	logic signed [23:0]   sc_conv;
	logic signed [23:0]   y_nxt;
	logic signed [31:0]   s1_nxt;
	logic signed [31:0]   s2_nxt;
	logic [23:0]          y_mag;
	logic [22:0]          lvl;
	logic signed [PW-1:0] env_sum;
	logic [22:0]          env_nxt;
	logic [24:0]          sq;
	logic signed [21:0]   lg;
	logic signed [PW-1:0] db_r;
	logic signed [15:0]   db_nxt;
	logic signed [18:0]   twod;
	logic signed [18:0]   kk;
	logic signed [PW-1:0] hard_r;
	logic [14:0]          hard_red;
	logic signed [PW-1:0] num;
	logic [13:0]          r2;
	logic                 div_ge;
	logic [12:0]          rem_nxt;
	logic [15:0]          lf;
	logic [48:0]          bitv;
	logic [49:0]          trial;
	logic                 rt_ge;
	logic [48:0]          rv_nxt;
	logic [48:0]          rt_nxt;
	logic [4:0]           gsh;
	logic [16:0]          dry;

	assign sc_ext  = 32'(sample.sidechain_sample);
	assign sc_conv = (SB > 24) ? 24'(sc_ext >>> SC_SHR) : 24'(sc_ext <<< SC_SHL);

	assign y_nxt  = 24'(sskc_pkg::sat_s(sskc_pkg::rshr(p_q, 24) + PW'(s1_q), 24));
	assign s1_nxt = 32'(sskc_pkg::sat_s(sskc_pkg::rshr(-p_q, 22) + PW'(s2_q), 32));
	assign s2_nxt = 32'(sskc_pkg::sat_s(sskc_pkg::rshr(-PW'(acc_q) - p_q, 24), 32));

	assign y_mag = y_q[23] ? 24'(-y_q) : 24'(y_q);
	assign lvl   = y_mag[23] ? 23'h7FFFFF : y_mag[22:0];

	always_comb begin
		env_sum = $signed(PW'({1'b0, env_q})) + sskc_pkg::rshr(p_q, 24);
		if (env_sum < 0) begin
			env_nxt = '0;
		end else if (env_sum > PW'(sskc_pkg::LEVEL_MAX)) begin
			env_nxt = 23'h7FFFFF;
		end else begin
			env_nxt = env_sum[22:0];
		end
	end

	assign sq = p_q[47:23];
	assign lg = $signed({6'(6'd0 - {1'b0, exp_q}), frac_q});

	always_comb begin
		db_r = sskc_pkg::rshr(p_q, 24);
		if (db_r < PW'(sskc_pkg::DB_FLOOR)) begin
			db_nxt = 16'(sskc_pkg::DB_FLOOR);
		end else if (db_r > 0) begin
			db_nxt = '0;
		end else begin
			db_nxt = db_r[15:0];
		end
	end

	assign twod = {{1{diff_q[16]}}, diff_q, 1'b0};
	assign kk   = $signed({6'd0, knee_q});

	always_comb begin
		hard_r = sskc_pkg::rshr(p_q, 16);
		if (hard_r < 0) begin
			hard_red = '0;
		end else if (hard_r > PW'(sskc_pkg::RED_MAX)) begin
			hard_red = 15'(sskc_pkg::RED_MAX);
		end else begin
			hard_red = hard_r[14:0];
		end
	end

	assign num     = (p_q + $signed(PW'({knee_q, 19'd0}))) >>> 20;
	assign r2      = {rem_q, qn_q[11]};
	assign div_ge  = r2 >= {1'b0, knee_q};
	assign rem_nxt = div_ge ? 13'(r2 - {1'b0, knee_q}) : r2[12:0];

	assign lf     = l_q[15:0];
	assign bitv   = 49'd1 << {sb_q, 1'b0};
	assign trial  = {1'b0, rt_q} + {1'b0, bitv};
	assign rt_ge  = {1'b0, rv_q} >= trial;
	assign rv_nxt = rt_ge ? 49'({1'b0, rv_q} - trial) : rv_q;
	assign rt_nxt = rt_ge ? (rt_q >> 1) + bitv : rt_q >> 1;

	assign gsh = l_q[20:16];
	assign dry = 17'(17'd65536 - wet_c);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_F_B0: begin
				mul_a = $signed(MW'(b0_q));
				mul_b = MW'(sc_q);
			end
			ST_F_A1: begin
				mul_a = MW'(a1_q);
				mul_b = MW'(y_q);
			end
			ST_F_A2: begin
				mul_a = MW'(a2);
				mul_b = MW'(y_q);
			end
			ST_E_MUL: begin
				mul_a = $signed(MW'(cf_q));
				mul_b = MW'(ed_q);
			end
			ST_L_SQ: begin
				mul_a = $signed(MW'(m_q));
				mul_b = $signed(MW'(m_q));
			end
			ST_L_DB: begin
				mul_a = MW'(lg);
				mul_b = $signed(MW'(sskc_pkg::DB_PER_LOG2));
			end
			ST_K_SEL: begin
				mul_a = MW'(diff_q);
				mul_b = $signed(MW'(slope_c));
			end
			ST_K_UU: begin
				mul_a = $signed(MW'(u_q));
				mul_b = $signed(MW'(u_q));
			end
			ST_K_US: begin
				mul_a = $signed(MW'(p_q[27:0]));
				mul_b = $signed(MW'(slope_c));
			end
			ST_G_MUL: begin
				mul_a = $signed(MW'(red_q));
				mul_b = $signed(MW'(sskc_pkg::LOG2_PER_DB));
			end
			ST_M_GW: begin
				mul_a = $signed(MW'(g_q));
				mul_b = $signed(MW'(wet_c));
			end
			ST_M_X, ST_M_OUT: begin
				mul_a = MW'(x_q);
				mul_b = MW'(gm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			env_q       <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			thr_q       <= -16'sd5120;
			knee_q      <= 13'd1536;
			slope_q     <= 17'd49152;
			att_q       <= 25'd167772;
			rel_q       <= 25'd16777;
			wet_q       <= 17'd65536;
			b0_q        <= 24'd431000;
			a1_q        <= -24'sd7620000;
		end else begin
			if (cfg_valid) begin
				case (cfg_addr)
					sskc_pkg::REG_THRESHOLD: thr_q   <= cfg_wdata[15:0];
					sskc_pkg::REG_KNEE:      knee_q  <= cfg_wdata[12:0];
					sskc_pkg::REG_SLOPE:     slope_q <= cfg_wdata[16:0];
					sskc_pkg::REG_ATTACK:    att_q   <= cfg_wdata[24:0];
					sskc_pkg::REG_RELEASE:   rel_q   <= cfg_wdata[24:0];
					sskc_pkg::REG_WET:       wet_q   <= cfg_wdata[16:0];
					sskc_pkg::REG_BP_B0:     b0_q    <= cfg_wdata[23:0];
					sskc_pkg::REG_BP_A1:     a1_q    <= cfg_wdata[23:0];
					default: ;
				endcase
			end

			if (res_valid_q && result_ready && state_q != ST_M_OUT) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						x_q     <= sample.main_sample;
						sc_q    <= sc_conv;
						state_q <= ST_F_B0;
					end
				end
				ST_F_B0: state_q <= ST_F_Y;
				ST_F_Y: begin
					y_q     <= y_nxt;
					acc_q   <= p_q[47:0];
					state_q <= ST_F_A1;
				end
				ST_F_A1: state_q <= ST_F_A2;
				ST_F_A2: begin
					s1_q    <= s1_nxt;
					state_q <= ST_F_S2;
				end
				ST_F_S2: begin
					s2_q    <= s2_nxt;
					ed_q    <= $signed({1'b0, lvl}) - $signed({1'b0, env_q});
					cf_q    <= (lvl > env_q) ? att_c : rel_c;
					state_q <= ST_E_MUL;
				end
				ST_E_MUL: state_q <= ST_E_UPD;
				ST_E_UPD: begin
					env_q  <= env_nxt;
					m_q    <= 25'(env_nxt);
					exp_q  <= '0;
					frac_q <= '0;
					cnt_q  <= '0;
					if (env_nxt == '0) begin
						db_q    <= 16'(sskc_pkg::DB_FLOOR);
						state_q <= ST_K_DIFF;
					end else begin
						state_q <= ST_L_NORM;
					end
				end
				ST_L_NORM: begin
					if (m_q[23]) begin
						state_q <= ST_L_SQ;
					end else begin
						m_q   <= m_q << 1;
						exp_q <= exp_q + 5'd1;
					end
				end
				ST_L_SQ: state_q <= ST_L_FIX;
				ST_L_FIX: begin
					m_q    <= sq[24] ? sq >> 1 : sq;
					frac_q <= {frac_q[14:0], sq[24]};
					cnt_q  <= cnt_q + 4'd1;
					state_q <= (cnt_q == 4'd15) ? ST_L_DB : ST_L_SQ;
				end
				ST_L_DB: state_q <= ST_L_CLAMP;
				ST_L_CLAMP: begin
					db_q    <= db_nxt;
					state_q <= ST_K_DIFF;
				end
				ST_K_DIFF: begin
					diff_q  <= 17'(db_q) - 17'(thr_q);
					state_q <= ST_K_SEL;
				end
				ST_K_SEL: begin
					if (twod <= -kk) begin
						red_q   <= '0;
						state_q <= ST_G_MUL;
					end else if (twod >= kk) begin
						state_q <= ST_K_HARD;
					end else begin
						u_q     <= 14'(twod + kk);
						state_q <= ST_K_UU;
					end
				end
				ST_K_HARD: begin
					red_q   <= hard_red;
					state_q <= ST_G_MUL;
				end
				ST_K_UU: state_q <= ST_K_US;
				ST_K_US: state_q <= ST_K_NUM;
				ST_K_NUM: begin
					rem_q   <= num[24:12];
					qn_q    <= num[11:0];
					cnt_q   <= '0;
					state_q <= ST_K_DIV;
				end
				ST_K_DIV: begin
					rem_q <= rem_nxt;
					qn_q  <= {qn_q[10:0], div_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd11) begin
						red_q   <= 15'({qn_q[10:0], div_ge});
						state_q <= ST_G_MUL;
					end
				end
				ST_G_MUL: state_q <= ST_G_L;
				ST_G_L: begin
					l_q     <= 21'(sskc_pkg::rshr(p_q, 16));
					t_q     <= 25'd16777216;
					cnt_q   <= '0;
					state_q <= ST_R_INIT;
				end
				ST_R_INIT: begin
					rv_q    <= {t_q >> lf[cnt_q], 24'd0};
					rt_q    <= '0;
					sb_q    <= 5'd24;
					state_q <= ST_R_STEP;
				end
				ST_R_STEP: begin
					rv_q <= rv_nxt;
					rt_q <= rt_nxt;
					if (sb_q == '0) begin
						t_q     <= rt_nxt[24:0];
						cnt_q   <= cnt_q + 4'd1;
						state_q <= (cnt_q == 4'd15) ? ST_G_SHIFT : ST_R_INIT;
					end else begin
						sb_q <= sb_q - 5'd1;
					end
				end
				ST_G_SHIFT: begin
					g_q     <= (gsh > 5'd24) ? '0 : t_q >> gsh;
					state_q <= ST_M_GW;
				end
				ST_M_GW: state_q <= ST_M_G;
				ST_M_G: begin
					gm_q    <= 26'(sskc_pkg::rshr($signed(PW'({dry, 24'd0})) + p_q, 16));
					state_q <= ST_M_X;
				end
				ST_M_X: state_q <= ST_M_OUT;
				ST_M_OUT: begin
					if (!res_valid_q || result_ready) begin
						res_q.out_sample   <= SB'(sskc_pkg::sat_s(sskc_pkg::rshr(p_q, 24), SB));
						res_q.reduction_db <= red_q;
						res_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/sskc_chk.sv
// ----------------------------------------------------------------------------
// sskc_chk: port checker for the sidechain compressor
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sskc_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire sskc_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.reduction_db <= 15'd25600)
		else $error("reduction out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("request taken while busy");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !$rose(result_valid))
		else $error("result too early");

endmodule

bind sidechain_soft_knee_compressor sskc_chk u_sskc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

>>> tb/sidechain_soft_knee_compressor_tb.sv
// ----------------------------------------------------------------------------
// sidechain_soft_knee_compressor_tb: self-checking bench of the compressor
// Drives sample requests and register writes, predicts each result with a
// bit-exact model of the detector, knee and gain path, and checks every
// result field in order under random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sidechain_soft_knee_compressor_tb;

	localparam logic [sskc_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 4'd15;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam longint FULL_SCALE  = 8388607;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	sskc_pkg::sample_t sample;
	logic result_valid;
	logic result_ready;
	sskc_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [sskc_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [sskc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	sidechain_soft_knee_compressor DUT (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// predictor configuration and state
	logic signed [15:0] thr_q;
	logic [12:0] knee_q;
	logic [16:0] slope_q;
	logic [24:0] atk_q;
	logic [24:0] rel_q;
	logic [16:0] wet_q;
	logic [23:0] b0_q;
	logic signed [23:0] a1_q;
	longint bq_s1, bq_s2, env_lvl;

	sskc_pkg::result_t pending_results[$];
	int errors = 0;
	longint cycles = 0;
	int rx_hold = 0;
	bit no_idle = 0;
	logic long_hold = 1'b0;
	event long_stall_ev;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint env_to_db(longint e);
		int p;
		longint unsigned m;
		longint frac, lg, db;
		if (e == 0) return sskc_pkg::DB_FLOOR;
		p = 22;
		while (p > 0 && e[p] == 1'b0) p--;
		m = e << (23 - p);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 23;
			frac = frac << 1;
			if (m >= (longint'(1) << 24)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		lg = longint'(p - 23) * 65536 + frac;
		db = rnd_shr(lg * longint'(sskc_pkg::DB_PER_LOG2), 24);
		if (db < sskc_pkg::DB_FLOOR) db = sskc_pkg::DB_FLOOR;
		if (db > 0) db = 0;
		return db;
	endfunction

	function automatic longint knee_curve(longint db, longint slope);
		longint diff, k, red;
		longint unsigned u, d;
		diff = db - longint'(thr_q);
		k = longint'(knee_q);
		if (2 * diff <= -k) red = 0;
		else if (2 * diff >= k) red = rnd_shr(diff * slope, 16);
		else begin
			u = 2 * diff + k;
			d = longint'(knee_q) << 20;
			red = (u * u * slope + d / 2) / d;
		end
		if (red < 0) red = 0;
		if (red > sskc_pkg::RED_MAX) red = sskc_pkg::RED_MAX;
		return red;
	endfunction

	function automatic longint unsigned red_to_gain(longint red);
		longint lg;
		longint unsigned t;
		longint n;
		lg = rnd_shr(red * longint'(sskc_pkg::LOG2_PER_DB), 16);
		t = longint'(1) << 24;
		n = lg >> 16;
		for (int i = 0; i < 16; i++) t = int_sqrt((t >> lg[i]) << 24);
		return (n > 24) ? 0 : (t >> n);
	endfunction

	function automatic sskc_pkg::result_t compress_step(sskc_pkg::sample_t s);
		longint x, sc, b0, a1, a2, y, lvl, coeff, red, mix_g, o, slope, w;
		longint unsigned g;
		sskc_pkg::result_t r;
		x = longint'(s.main_sample);
		sc = longint'(s.sidechain_sample);
		b0 = longint'(b0_q);
		a1 = longint'(a1_q);
		a2 = (longint'(1) << 24) - 2 * b0;
		slope = (slope_q > 65536) ? 65536 : longint'(slope_q);
		w = (wet_q > 65536) ? 65536 : longint'(wet_q);
		y = clip(rnd_shr(b0 * sc, 24) + bq_s1, 24);
		bq_s1 = clip(rnd_shr(-a1 * y, 22) + bq_s2, 32);
		bq_s2 = clip(rnd_shr(-b0 * sc - a2 * y, 24), 32);
		lvl = (y < 0) ? -y : y;
		if (lvl > FULL_SCALE) lvl = FULL_SCALE;
		coeff = (lvl > env_lvl) ? longint'(atk_q) : longint'(rel_q);
		if (coeff > 16777216) coeff = 16777216;
		env_lvl += rnd_shr(coeff * (lvl - env_lvl), 24);
		if (env_lvl < 0) env_lvl = 0;
		if (env_lvl > FULL_SCALE) env_lvl = FULL_SCALE;
		red = knee_curve(env_to_db(env_lvl), slope);
		g = red_to_gain(red);
		mix_g = rnd_shr((65536 - w) * 16777216 + longint'(g) * w, 16);
		o = clip(rnd_shr(x * mix_g, 24), sskc_pkg::SAMPLE_BITS);
		r.out_sample = o[sskc_pkg::SAMPLE_BITS-1:0];
		r.reduction_db = red[sskc_pkg::RED_BITS-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		if (no_idle) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(50, 700);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(1, 4);
	endfunction

	task automatic send_sample(logic signed [23:0] main_s, logic signed [23:0] key_s);
		int gap;
		sample_valid <= 1'b1;
		sample.main_sample <= main_s;
		sample.sidechain_sample <= key_s;
		do @(posedge clk); while (!sample_ready);
		pending_results.push_back(compress_step({main_s, key_s}));
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [sskc_pkg::CFG_ADDR_W-1:0] idx,
		logic [sskc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sskc_pkg::REG_THRESHOLD: thr_q = val[15:0];
			sskc_pkg::REG_KNEE:      knee_q = val[12:0];
			sskc_pkg::REG_SLOPE:     slope_q = val[16:0];
			sskc_pkg::REG_ATTACK:    atk_q = val[24:0];
			sskc_pkg::REG_RELEASE:   rel_q = val[24:0];
			sskc_pkg::REG_WET:       wet_q = val[16:0];
			sskc_pkg::REG_BP_B0:     b0_q = val[23:0];
			sskc_pkg::REG_BP_A1:     a1_q = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_defaults();
		write_reg(sskc_pkg::REG_THRESHOLD, 25'(-5120));
		write_reg(sskc_pkg::REG_KNEE, 1536);
		write_reg(sskc_pkg::REG_SLOPE, 49152);
		write_reg(sskc_pkg::REG_ATTACK, 167772);
		write_reg(sskc_pkg::REG_RELEASE, 16777);
		write_reg(sskc_pkg::REG_WET, 65536);
		write_reg(sskc_pkg::REG_BP_B0, 431000);
		write_reg(sskc_pkg::REG_BP_A1, 25'(-7620000));
	endtask

	// long receiver hold, counted in its own process
	always begin
		@(long_stall_ev);
		long_hold <= 1'b1;
		repeat (3000) @(posedge clk);
		long_hold <= 1'b0;
	end

	// result checker and receiver stalls
	always @(posedge clk) begin
		int stall;
		sskc_pkg::result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result out=%0d red=%0d", $time,
					result.out_sample, result.reduction_db);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.out_sample !== exp_r.out_sample) begin
					$display("%0t: out_sample expected %0d actual %0d", $time,
						exp_r.out_sample, result.out_sample);
					errors++;
				end
				if (result.reduction_db !== exp_r.reduction_db) begin
					$display("%0t: reduction_db expected %0d actual %0d", $time,
						exp_r.reduction_db, result.reduction_db);
					errors++;
				end
			end
		end
		if (long_hold) begin
			result_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			result_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 1500)
				: $urandom_range(1, 5);
			rx_hold <= stall;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic test_default_path();
		send_sample(0, 0);
		send_sample(24'sh7FFFFF, 24'sh7FFFFF);
		send_sample(24'sh800000, 24'sh800000);
		send_sample(24'sh800000, 24'sh7FFFFF);
		send_sample(24'sh7FFFFF, 24'sh800000);
		for (int i = 0; i < 10; i++)
			send_sample(24'($urandom), (i % 2) ? 24'sh800000 : 24'sh7FFFFF);
		drain();
	endtask

	task automatic test_hard_knee_deep();
		write_reg(sskc_pkg::REG_KNEE, 0);
		write_reg(sskc_pkg::REG_THRESHOLD, 25'(-25600));
		write_reg(sskc_pkg::REG_SLOPE, 65536);
		write_reg(sskc_pkg::REG_ATTACK, 16777216);
		write_reg(sskc_pkg::REG_RELEASE, 25'h1FFFFFF);
		write_reg(REG_UNMAPPED, 25'h1ABCDEF);
		for (int i = 0; i < 6; i++) send_sample(24'sh7FFFFF, 24'($urandom));
		send_sample(24'sh800000, 24'sh800000);
		drain();
	endtask

	task automatic test_unstable_filter();
		write_reg(sskc_pkg::REG_BP_B0, 25'(24'hFFFFFF));
		write_reg(sskc_pkg::REG_BP_A1, 25'(24'sh800000));
		write_reg(sskc_pkg::REG_WET, 0);
		for (int i = 0; i < 5; i++) send_sample(24'($urandom), 24'sh7FFFFF);
		drain();
		write_reg(sskc_pkg::REG_BP_A1, 25'(24'sh7FFFFF));
		write_reg(sskc_pkg::REG_WET, 25'(17'h1FFFF));
		write_reg(sskc_pkg::REG_SLOPE, 25'(17'h1FFFF));
		write_reg(sskc_pkg::REG_KNEE, 25'(13'h1FFF));
		write_reg(sskc_pkg::REG_THRESHOLD, 0);
		for (int i = 0; i < 5; i++) send_sample(24'($urandom), 24'sh800000);
		drain();
	endtask

	task automatic random_config();
		write_reg(sskc_pkg::REG_THRESHOLD, $urandom_range(0, 3) == 0 ? 25'($urandom)
			: 25'(-$signed($urandom_range(0, 25600))));
		write_reg(sskc_pkg::REG_KNEE, 25'($urandom_range(0, 4) == 0
			? $urandom_range(0, 8191) : $urandom_range(0, 6144)));
		write_reg(sskc_pkg::REG_SLOPE, 25'($urandom_range(0, 4) == 0
			? $urandom_range(0, 131071) : $urandom_range(0, 65536)));
		write_reg(sskc_pkg::REG_ATTACK, 25'($urandom_range(0, 3) == 0 ? $urandom
			: $urandom_range(1000, 4000000)));
		write_reg(sskc_pkg::REG_RELEASE, 25'($urandom_range(0, 3) == 0 ? $urandom
			: $urandom_range(100, 400000)));
		write_reg(sskc_pkg::REG_WET, 25'($urandom_range(0, 4) == 0
			? $urandom_range(0, 131071) : $urandom_range(0, 65536)));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(sskc_pkg::REG_BP_B0, 25'($urandom));
			write_reg(sskc_pkg::REG_BP_A1, 25'($urandom));
		end else begin
			write_reg(sskc_pkg::REG_BP_B0, 25'($urandom_range(20000, 1200000)));
			write_reg(sskc_pkg::REG_BP_A1,
				25'(-$signed($urandom_range(5000000, 8300000))));
		end
	endtask

	task automatic test_random_phases();
		int shift;
		logic signed [23:0] key;
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			no_idle = (ph == 3);
			for (int i = 0; i < 200; i++) begin
				if (i % 25 == 0) shift = $urandom_range(0, 23);
				key = $signed(24'($urandom)) >>> shift;
				send_sample(24'($urandom), key);
			end
			no_idle = 0;
			drain();
		end
	endtask

	task automatic test_backpressure();
		load_defaults();
		@(posedge clk);
		-> long_stall_ev;
		for (int i = 0; i < 6; i++) send_sample(24'($urandom), 24'($urandom));
		drain();
		for (int i = 0; i < 40; i++) send_sample(24'($urandom), 24'($urandom));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		thr_q = -5120; knee_q = 1536; slope_q = 49152; atk_q = 167772;
		rel_q = 16777; wet_q = 65536; b0_q = 431000; a1_q = -7620000;
		bq_s1 = 0; bq_s2 = 0; env_lvl = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_path();
		test_hard_knee_deep();
		test_unstable_filter();
		test_random_phases();
		test_backpressure();
		drain();
		repeat (600) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/sskc_pkg.sv
hw/rtl/sskc_mul.sv
hw/rtl/sidechain_soft_knee_compressor.sv
hw/rtl/sskc_chk.sv
tb/sidechain_soft_knee_compressor_tb.sv
